@@ hdl/ftt_pkg.sv @@
// Package for the frame timer table: types, codes and shared constants.
`default_nettype none

package ftt_pkg;

  // Default table depth
  localparam int MAX_TIMERS = 30;

  // Command codes of an input request
  localparam logic [2:0] OP_ADD_ONCE   = 3'd0;
  localparam logic [2:0] OP_ADD_REPEAT = 3'd1;
  localparam logic [2:0] OP_KILL       = 3'd2;
  localparam logic [2:0] OP_CLEAR      = 3'd3;
  localparam logic [2:0] OP_TICK       = 3'd4;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_OK    = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_DONE  = 2'd3
  } ftt_kind_t;

  // Input request payload
  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] prog_id;
    logic [15:0] frames;
  } ftt_in_t;

  // Result payload
  typedef struct packed {
    ftt_kind_t   kind;
    logic [15:0] fired_id;
    logic        last;
  } ftt_out_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] count;
    logic [15:0] reload;
    logic        dead;
  } ftt_entry_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DEC,
    S_EVAL,
    S_FIN
  } ftt_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_in;    // latch the input request
    logic walk_init;  // restart the table walk at entry zero
    logic walk_step;  // retire the current entry, advance
    logic emit_fire;  // load a fired result into the output register
    logic finish;     // apply end-of-command update, load final result
  } ftt_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic op_walk;    // latched command walks the table
    logic walk_empty; // table holds no entries
    logic walk_last;  // current entry is the last one
    logic fire;       // current entry fires on this tick
    logic slot_free;  // output register can take a result this cycle
  } ftt_sts_t;

endpackage

`default_nettype wire

@@ hdl/ftt_ctrl.sv @@
// Controller state machine for the frame timer table.
`default_nettype none

module ftt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ftt_pkg::ftt_sts_t sts,
  output ftt_pkg::ftt_ctl_t      ctl
);

  ftt_pkg::ftt_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ftt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.take_in = 1'b1;
          state_nxt   = ftt_pkg::S_DEC;
        end
      end
      ftt_pkg::S_DEC: begin
        // restart the walk even on an empty table so the keep count is zero
        ctl.walk_init = sts.op_walk;
        if (sts.op_walk && !sts.walk_empty) begin
          state_nxt = ftt_pkg::S_EVAL;
        end else begin
          state_nxt = ftt_pkg::S_FIN;
        end
      end
      ftt_pkg::S_EVAL: begin
        // a firing entry waits for room in the output register
        if (!sts.fire || sts.slot_free) begin
          ctl.walk_step = 1'b1;
          ctl.emit_fire = sts.fire;
          if (sts.walk_last) begin
            state_nxt = ftt_pkg::S_FIN;
          end
        end
      end
      ftt_pkg::S_FIN: begin
        if (sts.slot_free) begin
          ctl.finish = 1'b1;
          state_nxt  = ftt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ftt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/ftt_dp.sv @@
// Datapath for the frame timer table: entry memory, walk counters, result register.
`default_nettype none

module ftt_dp #(
  parameter int MAX_TIMERS = ftt_pkg::MAX_TIMERS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ftt_pkg::ftt_in_t  in_data,
  input  wire ftt_pkg::ftt_ctl_t ctl,
  output ftt_pkg::ftt_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ftt_pkg::ftt_out_t      out_data
);

  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TIMERS);

  // Entry memory
  ftt_pkg::ftt_entry_t mem [MAX_TIMERS];

  ftt_pkg::ftt_in_t    in_r;
  ftt_pkg::ftt_entry_t rd_data_r;
  logic [CW-1:0]       used_r, used_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       keep_r, keep_nxt;
  logic                out_valid_r, out_valid_nxt;
  ftt_pkg::ftt_out_t   out_data_r, out_data_nxt;

  logic [CW-1:0]       idx_inc;
  logic [CW-1:0]       rd_idx;
  logic                is_tick, is_kill, is_repeat;
  logic                fires;
  logic                we;
  logic [AW-1:0]       wr_addr;
  ftt_pkg::ftt_entry_t wr_data;

  // Decode and status
  assign is_tick   = (in_r.cmd == ftt_pkg::OP_TICK);
  assign is_kill   = (in_r.cmd == ftt_pkg::OP_KILL);
  assign is_repeat = (in_r.cmd == ftt_pkg::OP_ADD_REPEAT);
  assign idx_inc   = idx_r + CW'(1);
  assign fires     = is_tick && !rd_data_r.dead && (rd_data_r.count <= 16'd1);

  assign sts.op_walk    = is_tick || is_kill;
  assign sts.walk_empty = (used_r == '0);
  assign sts.walk_last  = (idx_inc == used_r);
  assign sts.fire       = fires;
  assign sts.slot_free  = !out_valid_r || out_ready;

  // Read one entry ahead so the walk retires one entry per cycle unless a firing entry waits for the output register
  assign rd_idx = ctl.walk_init ? '0 : (ctl.walk_step ? idx_inc : idx_r);

  // Entry updates, counters and result loading
  always_comb begin
    we            = 1'b0;
    wr_addr       = keep_r[AW-1:0];
    wr_data       = rd_data_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    keep_nxt      = keep_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (ctl.walk_init) begin
      idx_nxt  = '0;
      keep_nxt = '0;
    end

    if (ctl.walk_step) begin
      idx_nxt = idx_inc;
      if (is_kill) begin
        // mark matching entries dead in place
        we           = 1'b1;
        wr_addr      = idx_r[AW-1:0];
        wr_data.dead = rd_data_r.dead || (rd_data_r.id == in_r.prog_id);
      end else if (is_tick && !rd_data_r.dead) begin
        // survivors are compacted down to the keep position
        wr_data.dead = 1'b0;
        if (fires) begin
          if (rd_data_r.reload != 16'd0) begin
            we            = 1'b1;
            wr_data.count = rd_data_r.reload;
            keep_nxt      = keep_r + CW'(1);
          end
        end else begin
          we            = 1'b1;
          wr_data.count = rd_data_r.count - 16'd1;
          keep_nxt      = keep_r + CW'(1);
        end
      end
    end

    if (ctl.emit_fire) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.kind     = ftt_pkg::KIND_FIRED;
      out_data_nxt.fired_id = rd_data_r.id;
      out_data_nxt.last     = 1'b0;
    end

    if (ctl.finish) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.kind     = ftt_pkg::KIND_OK;
      out_data_nxt.fired_id = 16'd0;
      out_data_nxt.last     = 1'b1;
      unique case (in_r.cmd)
        ftt_pkg::OP_ADD_ONCE, ftt_pkg::OP_ADD_REPEAT: begin
          if (used_r < FULL_CNT) begin
            we             = 1'b1;
            wr_addr        = used_r[AW-1:0];
            wr_data.id     = in_r.prog_id;
            wr_data.count  = in_r.frames;
            wr_data.reload = is_repeat ? in_r.frames : 16'd0;
            wr_data.dead   = 1'b0;
            used_nxt       = used_r + CW'(1);
          end else begin
            out_data_nxt.kind = ftt_pkg::KIND_FULL;
          end
        end
        ftt_pkg::OP_CLEAR: begin
          used_nxt = '0;
        end
        ftt_pkg::OP_TICK: begin
          used_nxt          = keep_r;
          out_data_nxt.kind = ftt_pkg::KIND_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  // Memory write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_idx[AW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      idx_r       <= '0;
      keep_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      idx_r       <= idx_nxt;
      keep_r      <= keep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      in_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ hdl/frame_timer_table.sv @@
// Top level of the frame timer table: controller plus datapath.
//
// Input channel in_valid/in_ready/in_data carries one command request:
// add one-shot, add repeating, kill by id, clear all, or tick. Result
// channel out_valid/out_ready/out_data returns the results of each request
// in order; the final result of a request has last set. Add, kill, clear
// and unknown commands give one result; a tick gives one fired result per
// expiring timer in table order, then a tick-done result.
// Timing: one request is handled at a time. Add, clear and unknown
// commands pass through the decode and finish states before the request
// port is ready again; kill and tick also walk every entry in the table
// through the single read port of the entry memory, which visits one entry
// per cycle unless a firing entry waits for room in the output register.
// A short command's result is loaded into the output register in the finish state.
// A result waiting in the output register does not block acceptance of the
// next request; when the receiver stalls, the walk pauses at the next entry
// that must emit a result until the output register drains.
// Reset empties the table and drops any pending result; the entry memory
// itself is not cleared, as only entries below the fill count are read.
`default_nettype none

module frame_timer_table #(
  parameter int MAX_TIMERS = ftt_pkg::MAX_TIMERS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ftt_pkg::ftt_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ftt_pkg::ftt_out_t     out_data
);

  ftt_pkg::ftt_ctl_t ctl;
  ftt_pkg::ftt_sts_t sts;

  // Sequencer
  ftt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Table storage and result register
  ftt_dp #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ hdl/ftt_checker.sv @@
// Port-level assertions for the frame timer table, bound to the top level.
`default_nettype none

module ftt_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire ftt_pkg::ftt_out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Fired results are never the final result of a request
  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == ftt_pkg::KIND_FIRED) |-> !out_data.last)
    else $error("fired result marked last");

  // Every other result closes its request and carries no id
  a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != ftt_pkg::KIND_FIRED) |->
      out_data.last && (out_data.fired_id == 16'd0))
    else $error("non-fired result not last or has id");

  // Reset drops any pending result
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_timer_table ftt_checker u_ftt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/frame_timer_checker.sv @@
// Scoreboard for the frame timer table: tracks the timer table and checks every result.
`timescale 1ns / 1ps

module frame_timer_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  ftt_pkg::ftt_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  ftt_pkg::ftt_out_t out_data,
  output int                errors,
  output int                pending
);

  localparam int MAX_REPORTS = 10;

  // Shadow copy of the timer table
  logic [15:0] tmr_id     [ftt_pkg::MAX_TIMERS];
  logic [15:0] tmr_count  [ftt_pkg::MAX_TIMERS];
  logic [15:0] tmr_reload [ftt_pkg::MAX_TIMERS];
  bit          tmr_dead   [ftt_pkg::MAX_TIMERS];
  int          fill;

  // Results still owed by the block, oldest first
  ftt_pkg::ftt_out_t owed_results[$];

  function automatic ftt_pkg::ftt_out_t result_of(ftt_pkg::ftt_kind_t kind,
                                                  logic [15:0] id, logic last);
    ftt_pkg::ftt_out_t r;
    r.kind     = kind;
    r.fired_id = id;
    r.last     = last;
    return r;
  endfunction

  // Queue one owed result at the tail
  task automatic owe_result(input ftt_pkg::ftt_out_t r);
    owed_results.insert(owed_results.size(), r);
  endtask

  // Append a timer; dead entries not yet swept still take a slot
  function automatic ftt_pkg::ftt_kind_t add_timer(logic [15:0] id, logic [15:0] count,
                                                   logic [15:0] reload);
    if (fill >= ftt_pkg::MAX_TIMERS) return ftt_pkg::KIND_FULL;
    tmr_id[fill]     = id;
    tmr_count[fill]  = count;
    tmr_reload[fill] = reload;
    tmr_dead[fill]   = 1'b0;
    fill++;
    return ftt_pkg::KIND_OK;
  endfunction

  // Apply one request to the shadow table and queue the results it causes
  task automatic run_timer_cmd(input ftt_pkg::ftt_in_t req);
    int i;
    int keep;
    case (req.cmd)
      ftt_pkg::OP_ADD_ONCE: begin
        owe_result(result_of(add_timer(req.prog_id, req.frames, 16'd0), 16'd0, 1'b1));
      end
      ftt_pkg::OP_ADD_REPEAT: begin
        owe_result(result_of(add_timer(req.prog_id, req.frames, req.frames),
                             16'd0, 1'b1));
      end
      ftt_pkg::OP_KILL: begin
        for (i = 0; i < fill; i++)
          if (tmr_id[i] == req.prog_id) tmr_dead[i] = 1'b1;
        owe_result(result_of(ftt_pkg::KIND_OK, 16'd0, 1'b1));
      end
      ftt_pkg::OP_CLEAR: begin
        fill = 0;
        owe_result(result_of(ftt_pkg::KIND_OK, 16'd0, 1'b1));
      end
      ftt_pkg::OP_TICK: begin
        // count down live timers; a count of 0 or 1 expires now
        for (i = 0; i < fill; i++) begin
          if (!tmr_dead[i]) begin
            if (tmr_count[i] <= 16'd1) begin
              owe_result(result_of(ftt_pkg::KIND_FIRED, tmr_id[i], 1'b0));
              if (tmr_reload[i] != 16'd0) tmr_count[i] = tmr_reload[i];
              else tmr_dead[i] = 1'b1;
            end else begin
              tmr_count[i] = tmr_count[i] - 16'd1;
            end
          end
        end
        // sweep dead entries, survivors keep their order
        keep = 0;
        for (i = 0; i < fill; i++) begin
          if (!tmr_dead[i]) begin
            tmr_id[keep]     = tmr_id[i];
            tmr_count[keep]  = tmr_count[i];
            tmr_reload[keep] = tmr_reload[i];
            tmr_dead[keep]   = 1'b0;
            keep++;
          end
        end
        fill = keep;
        owe_result(result_of(ftt_pkg::KIND_DONE, 16'd0, 1'b1));
      end
      default: begin
        owe_result(result_of(ftt_pkg::KIND_OK, 16'd0, 1'b1));
      end
    endcase
  endtask

  // Compare one accepted result with the oldest owed one
  task automatic match_result(input ftt_pkg::ftt_out_t got);
    ftt_pkg::ftt_out_t want;
    if (owed_results.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("[%0t] unexpected result: kind %0d id %h last %0d",
                 $time, got.kind, got.fired_id, got.last);
    end else begin
      want = owed_results.pop_front();
      if (got.kind !== want.kind || got.fired_id !== want.fired_id ||
          got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"[%0t] mismatch: expected kind %0d id %h last %0d,",
                    " got kind %0d id %h last %0d"},
                   $time, want.kind, want.fired_id, want.last,
                   got.kind, got.fired_id, got.last);
      end
    end
  endtask

  // Watch both channels; a request is applied before a result in the same cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      owed_results.delete();
    end else begin
      if (in_valid && in_ready) run_timer_cmd(in_data);
      if (out_valid && out_ready) match_result(out_data);
    end
    pending = owed_results.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the frame timer table testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int N_ITEMS     = 480;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int TAIL_CYCLES = 50;

  // Receiver behavior modes
  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_BURSTY
  } rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ftt_pkg::ftt_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ftt_pkg::ftt_out_t out_data;

  int       errors;
  int       pending;
  int       sent = 0;
  int       burst_left = 0;
  int       cycles = 0;

  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;
  int       stall_left = 0;

  frame_timer_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  frame_timer_checker timer_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: free-running, coin-flip or long stalls, switching every so often
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode    = rx_mode_t'($urandom_range(2, 0));
      rx_left    = $urandom_range(200, 20);
      stall_left = 0;
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE: out_ready <= 1'b1;
      RX_COIN: out_ready <= ($urandom_range(3, 0) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(7, 0) == 0) stall_left = $urandom_range(40, 1);
        end
      end
    endcase
  end

  function automatic ftt_pkg::ftt_in_t make_req(logic [2:0] cmd, logic [15:0] id,
                                                logic [15:0] frames);
    ftt_pkg::ftt_in_t r;
    r.cmd     = cmd;
    r.prog_id = id;
    r.frames  = frames;
    return r;
  endfunction

  // Mostly a small pool of ids so kills hit; sometimes any id
  function automatic logic [15:0] pick_id();
    if ($urandom_range(4, 0) == 0) return 16'($urandom);
    return 16'h3C00 | 16'($urandom_range(7, 0));
  endfunction

  // Short counts dominate so timers expire often
  function automatic logic [15:0] pick_frames();
    int p;
    p = $urandom_range(99, 0);
    if (p < 45) return 16'($urandom_range(3, 0));
    if (p < 80) return 16'($urandom_range(12, 4));
    if (p < 92) return 16'($urandom_range(200, 13));
    return 16'($urandom);
  endfunction

  function automatic ftt_pkg::ftt_in_t rand_req();
    int p;
    logic [2:0] cmd;
    p = $urandom_range(99, 0);
    if (p < 28)      cmd = ftt_pkg::OP_ADD_ONCE;
    else if (p < 52) cmd = ftt_pkg::OP_ADD_REPEAT;
    else if (p < 62) cmd = ftt_pkg::OP_KILL;
    else if (p < 64) cmd = ftt_pkg::OP_CLEAR;
    else if (p < 97) cmd = ftt_pkg::OP_TICK;
    else             cmd = ftt_pkg::OP_TICK + 3'($urandom_range(3, 1));  // unused codes
    return make_req(cmd, pick_id(), pick_frames());
  endfunction

  // Present one request and hold it until accepted
  task automatic send_req(input ftt_pkg::ftt_in_t req);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (req.cmd <= ftt_pkg::OP_TICK) sent++;
  endtask

  // Burst pacing: random gap once the current burst runs out
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(4, 0) == 0) ? $urandom_range(20, 1) : $urandom_range(3, 1);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(30, 0);
    end
  endtask

  // Hold off until every owed result has come back
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_paced(input ftt_pkg::ftt_in_t req);
    send_req(req);
    pace();
  endtask

  initial begin
    ftt_pkg::ftt_in_t req;
    logic [15:0]      first_id;

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: empty table, extremes, zero-count and repeat-with-zero timers
    send_paced(make_req(ftt_pkg::OP_TICK,       16'h0000, 16'h0000));
    send_paced(make_req(ftt_pkg::OP_KILL,       16'hFFFF, 16'hFFFF));  // no match
    send_paced(make_req(ftt_pkg::OP_ADD_ONCE,   16'h0000, 16'h0000));
    send_paced(make_req(ftt_pkg::OP_ADD_ONCE,   16'hFFFF, 16'h0001));
    send_paced(make_req(ftt_pkg::OP_ADD_REPEAT, 16'h1234, 16'h0000));  // acts as one-shot
    send_paced(make_req(ftt_pkg::OP_ADD_REPEAT, 16'hABCD, 16'h0002));
    send_paced(make_req(ftt_pkg::OP_ADD_ONCE,   16'h5555, 16'hFFFF));
    send_paced(make_req(ftt_pkg::OP_ADD_REPEAT, 16'h5555, 16'h0003));
    send_paced(make_req(ftt_pkg::OP_TICK,       16'h0000, 16'h0000));
    send_paced(make_req(ftt_pkg::OP_TICK,       16'hFFFF, 16'hFFFF));  // reload path
    send_paced(make_req(ftt_pkg::OP_KILL,       16'h5555, 16'h0000));  // two matches
    send_paced(make_req(ftt_pkg::OP_TICK,       16'h0000, 16'h0000));
    send_paced(make_req(3'b111,                 16'hFFFF, 16'hFFFF));  // unused code
    send_paced(make_req(ftt_pkg::OP_ADD_REPEAT, 16'hAAAA, 16'h8000));
    send_paced(make_req(ftt_pkg::OP_CLEAR,      16'hFFFF, 16'hFFFF));
    send_paced(make_req(ftt_pkg::OP_TICK,       16'h0000, 16'h0000));
    drain();

    // Full table: every live timer fires on each tick, killed entries still hold slots
    first_id = 16'($urandom);
    send_paced(make_req(ftt_pkg::OP_ADD_REPEAT, first_id, 16'd1));
    repeat (ftt_pkg::MAX_TIMERS - 1)
      send_paced(make_req(ftt_pkg::OP_ADD_REPEAT, 16'($urandom), 16'd1));
    send_paced(make_req(ftt_pkg::OP_ADD_ONCE,   16'($urandom), 16'd5));
    send_paced(make_req(ftt_pkg::OP_TICK,       16'($urandom), 16'($urandom)));
    send_paced(make_req(ftt_pkg::OP_KILL,       first_id, 16'd0));
    send_paced(make_req(ftt_pkg::OP_ADD_REPEAT, 16'($urandom), 16'd2));
    send_paced(make_req(ftt_pkg::OP_TICK,       16'($urandom), 16'($urandom)));
    send_paced(make_req(ftt_pkg::OP_ADD_ONCE,   16'($urandom), 16'd0));
    send_paced(make_req(ftt_pkg::OP_TICK,       16'($urandom), 16'($urandom)));
    drain();

    // Clear after a tick left survivors, then tick the empty table
    send_paced(make_req(ftt_pkg::OP_ADD_REPEAT, 16'h0101, 16'd5));
    send_paced(make_req(ftt_pkg::OP_ADD_REPEAT, 16'h0202, 16'd5));
    send_paced(make_req(ftt_pkg::OP_TICK,       16'h0000, 16'h0000));
    send_paced(make_req(ftt_pkg::OP_CLEAR,      16'h0000, 16'h0000));
    send_paced(make_req(ftt_pkg::OP_TICK,       16'h0000, 16'h0000));
    send_paced(make_req(ftt_pkg::OP_ADD_ONCE,   16'h0303, 16'd1));
    send_paced(make_req(ftt_pkg::OP_TICK,       16'h0000, 16'h0000));
    drain();

    // Random mix of adds, kills, clears and ticks
    while (sent < N_ITEMS) begin
      req = rand_req();
      send_paced(req);
      if ($urandom_range(99, 0) == 0) drain();
    end

    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
